// ===== rtl/core/fac_pkg.sv =====
package fac_pkg;

  localparam int unsigned MAX_RUN_DEF   = 65536;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int DATA_W = 64;
  localparam int IN_W   = 32;
  localparam int ERR_W  = 31;
  localparam int SKIP_W = 16;
  localparam int STEP_W = 7;

  // result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_ZERO_DIV = 2'd1;
  localparam logic [1:0] STAT_SAT      = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_MODE = 1'b0;
  localparam logic CFG_IDX_SKIP = 1'b1;

  // metric modes
  localparam logic MODE_CHI_SQ  = 1'b0;
  localparam logic MODE_REL_ERR = 1'b1;

  localparam logic signed [DATA_W-1:0] SUM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SUM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_SQ,
    S_SQE,
    S_OVF,
    S_DIV,
    S_TERM,
    S_ADD,
    S_END,
    S_FSGN,
    S_OUT
  } fac_state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DATA_W-1:0] rem_init;
    logic [DATA_W-1:0] quo_init;
    logic [DATA_W-1:0] dvs;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/fit_error_accumulator_core.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    theory, observed, error value, last item
// out_     output     out_valid/out_ready  result value, status code
// cfg_     input      cfg_valid/cfg_ready  cfg_index (0 mode, 1 skip count), cfg_data
//
// One item at a time; in_ready is high only in the idle state.
// A dropped item skips the squarer and the divider; kept items that divide do so on the
// radix-2 divider, one quotient bit a cycle.
// A last item adds a final division only in mode 1 with a nonempty run (the division
// by the count).
// A pending result holds the block in its output state until the output register frees.
// Reset is synchronous; it clears the configuration, run state, output valid and the state machine.
module fit_error_accumulator_core
  import fac_pkg::*;
#(
  parameter int unsigned MAX_RUN   = MAX_RUN_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [IN_W-1:0]   in_theory_value,
  input  logic signed [IN_W-1:0]   in_observed_value,
  input  logic        [ERR_W-1:0]  in_error_value,
  input  logic                     in_last_item,

  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_result_value,
  output logic        [1:0]        out_status_code,

  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [SKIP_W-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);
  localparam int CMP_W = (CNT_W > SKIP_W) ? CNT_W + 1 : SKIP_W + 1;
  localparam int HI_SH = DATA_W - 1 - FRAC_BITS;
  localparam logic [STEP_W-1:0] STEPS_CHI = STEP_W'(DATA_W - 1);
  localparam logic [STEP_W-1:0] STEPS_REL = STEP_W'(IN_W + FRAC_BITS);
  localparam logic [STEP_W-1:0] STEPS_AVG = STEP_W'(DATA_W);

  fac_state_t state_r, state_nxt;

  logic                     mode_r, mode_nxt;
  logic [SKIP_W-1:0]        skip_r, skip_nxt;
  logic                     run_mode_r, run_mode_nxt;
  logic signed [IN_W-1:0]   th_r, th_nxt;
  logic signed [IN_W-1:0]   ob_r, ob_nxt;
  logic [ERR_W-1:0]         e_r, e_nxt;
  logic                     last_r, last_nxt;
  logic                     keep_r, keep_nxt;
  logic [IN_W-1:0]          mag_r, mag_nxt;
  logic [DATA_W-1:0]        prod_r, prod_nxt;
  logic [DATA_W-1:0]        sq_r, sq_nxt;
  logic signed [DATA_W-1:0] term_r, term_nxt;
  logic signed [DATA_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [1:0]               flags_r, flags_nxt;
  logic                     final_r, final_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic [1:0]               res_stat_r, res_stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  logic [IN_W-1:0]          mul_a, mul_b;
  logic [DATA_W-1:0]        mul_p;
  logic [IN_W:0]            diff_full;
  logic [IN_W:0]            diff_abs;
  logic [IN_W-1:0]          ob_abs;
  logic [CMP_W-1:0]         count_ext, skip_ext, kept;
  logic [DATA_W-1:0]        sq_hi, sq_lo;
  logic [DATA_W-1:0]        sum_abs;
  logic signed [DATA_W-1:0] sum_add;
  logic                     add_ovf;

  div_cmd_t          div_cmd;
  div_stat_t         div_stat;
  logic [DATA_W-1:0] div_quo;

  fac_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .stat (div_stat),
    .quo  (div_quo)
  );

  assign diff_full = {th_r[IN_W-1], th_r} - {ob_r[IN_W-1], ob_r};
  assign diff_abs  = diff_full[IN_W] ? -diff_full : diff_full;
  assign ob_abs    = ob_r[IN_W-1] ? -ob_r : ob_r;
  assign count_ext = CMP_W'(count_r);
  assign skip_ext  = CMP_W'(skip_r);
  assign kept      = (count_ext > skip_ext) ? count_ext - skip_ext : '0;
  assign sq_hi     = sq_r >> HI_SH;
  assign sq_lo     = sq_r << FRAC_BITS;
  assign sum_abs   = sum_r[DATA_W-1] ? -sum_r : sum_r;
  assign sum_add   = sum_r + term_r;
  assign add_ovf   = (sum_r[DATA_W-1] == term_r[DATA_W-1]) &&
                     (sum_add[DATA_W-1] != sum_r[DATA_W-1]);

  // shared squarer: the difference first, then the uncertainty
  assign mul_a = (state_r == S_SQE) ? IN_W'(e_r) : mag_r;
  assign mul_b = mul_a;
  assign mul_p = DATA_W'(mul_a) * DATA_W'(mul_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    skip_nxt       = skip_r;
    run_mode_nxt   = run_mode_r;
    th_nxt         = th_r;
    ob_nxt         = ob_r;
    e_nxt          = e_r;
    last_nxt       = last_r;
    keep_nxt       = keep_r;
    mag_nxt        = mag_r;
    prod_nxt       = prod_r;
    sq_nxt         = sq_r;
    term_nxt       = term_r;
    sum_nxt        = sum_r;
    count_nxt      = count_r;
    flags_nxt      = flags_r;
    final_nxt      = final_r;
    res_nxt        = res_r;
    res_stat_nxt   = res_stat_r;
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    div_cmd        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_IDX_MODE: mode_nxt = cfg_data[0];
        CFG_IDX_SKIP: skip_nxt = cfg_data;
        default:      mode_nxt = mode_r;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          th_nxt       = in_theory_value;
          ob_nxt       = in_observed_value;
          e_nxt        = in_error_value;
          last_nxt     = in_last_item;
          run_mode_nxt = mode_r;
          keep_nxt     = 1'b0;
          if (count_r < CNT_W'(MAX_RUN)) begin
            count_nxt = count_r + CNT_W'(1);
            keep_nxt  = (count_ext >= skip_ext);
          end
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        mag_nxt   = diff_abs[IN_W-1:0];
        state_nxt = S_END;
        if (keep_r) begin
          if (run_mode_r == MODE_CHI_SQ) begin
            if (e_r == '0) begin
              flags_nxt[0] = 1'b1;
            end else begin
              state_nxt = S_SQ;
            end
          end else begin
            if (ob_r == '0) begin
              flags_nxt[0] = 1'b1;
            end else begin
              // |d| << FRAC_BITS, top-aligned in the dividend
              div_cmd.start    = 1'b1;
              div_cmd.steps    = STEPS_REL;
              div_cmd.rem_init = '0;
              div_cmd.quo_init = {diff_abs[IN_W-1:0], {(DATA_W-IN_W){1'b0}}};
              div_cmd.dvs      = DATA_W'(ob_abs);
              final_nxt        = 1'b0;
              state_nxt        = S_DIV;
            end
          end
        end
      end
      S_SQ: begin
        prod_nxt  = mul_p;
        state_nxt = S_SQE;
      end
      S_SQE: begin
        sq_nxt    = prod_r;
        prod_nxt  = mul_p;
        state_nxt = S_OVF;
      end
      S_OVF: begin
        // quotient would reach 2^63: clamp without dividing
        if (sq_hi >= prod_r) begin
          term_nxt     = SUM_MAX;
          flags_nxt[1] = 1'b1;
          state_nxt    = S_ADD;
        end else begin
          div_cmd.start    = 1'b1;
          div_cmd.steps    = STEPS_CHI;
          div_cmd.rem_init = sq_hi;
          div_cmd.quo_init = {sq_lo[DATA_W-2:0], 1'b0};
          div_cmd.dvs      = prod_r;
          final_nxt        = 1'b0;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = final_r ? S_FSGN : S_TERM;
        end
      end
      S_TERM: begin
        if (run_mode_r == MODE_REL_ERR && ob_r[IN_W-1]) begin
          term_nxt = -div_quo;
        end else begin
          term_nxt = div_quo;
        end
        state_nxt = S_ADD;
      end
      S_ADD: begin
        if (add_ovf) begin
          sum_nxt      = term_r[DATA_W-1] ? SUM_MIN : SUM_MAX;
          flags_nxt[1] = 1'b1;
        end else begin
          sum_nxt = sum_add;
        end
        state_nxt = S_END;
      end
      S_END: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else begin
          priority if (flags_r[1]) begin
            res_stat_nxt = STAT_SAT;
          end else if (flags_r[0]) begin
            res_stat_nxt = STAT_ZERO_DIV;
          end else begin
            res_stat_nxt = STAT_OK;
          end
          if (kept == '0) begin
            res_nxt      = '0;
            res_stat_nxt = STAT_EMPTY;
            state_nxt    = S_OUT;
          end else if (run_mode_r == MODE_CHI_SQ) begin
            res_nxt   = sum_r;
            state_nxt = S_OUT;
          end else begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = STEPS_AVG;
            div_cmd.rem_init = '0;
            div_cmd.quo_init = sum_abs;
            div_cmd.dvs      = DATA_W'(kept);
            final_nxt        = 1'b1;
            state_nxt        = S_DIV;
          end
        end
      end
      S_FSGN: begin
        res_nxt   = sum_r[DATA_W-1] ? -div_quo : div_quo;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register frees, then clear the run
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_r;
          out_status_nxt = res_stat_r;
          sum_nxt        = '0;
          count_nxt      = '0;
          flags_nxt      = '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b0;
      skip_r      <= '0;
      sum_r       <= '0;
      count_r     <= '0;
      flags_r     <= '0;
      final_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      skip_r      <= skip_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      final_r     <= final_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_mode_r   <= run_mode_nxt;
    th_r         <= th_nxt;
    ob_r         <= ob_nxt;
    e_r          <= e_nxt;
    last_r       <= last_nxt;
    keep_r       <= keep_nxt;
    mag_r        <= mag_nxt;
    prod_r       <= prod_nxt;
    sq_r         <= sq_nxt;
    term_r       <= term_nxt;
    res_r        <= res_nxt;
    res_stat_r   <= res_stat_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status_code  = out_status_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RUN))
    else $error("item count beyond run limit");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status_code == STAT_EMPTY) |-> (out_result_value == '0))
    else $error("empty run with nonzero result");

  a_div_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> div_stat.busy)
    else $error("waiting on an idle divider");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word taken while busy");

endmodule

// ===== rtl/core/fac_div.sv =====
module fac_div
  import fac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_cmd_t          cmd,
  output div_stat_t         stat,
  output logic [DATA_W-1:0] quo
);

  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] quo_r, quo_nxt;
  logic [DATA_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;

  logic [DATA_W-1:0] rem_sh;
  logic [DATA_W:0]   diff;
  logic              ge;

  // one restoring step: shift in the next dividend bit, try the subtract
  assign rem_sh = {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, dvs_r};
  assign ge     = ~diff[DATA_W];

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.start) begin
      rem_nxt  = cmd.rem_init;
      quo_nxt  = cmd.quo_init;
      dvs_nxt  = cmd.dvs;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DATA_W-1:0] : rem_sh;
      quo_nxt = {quo_r[DATA_W-2:0], ge};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == STEP_W'(1));
  assign quo       = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("divider started while busy");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == STEP_W'(1) && !cmd.start) |=> !busy_r)
    else $error("divider ran past its final step");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("divider busy with no steps left");

endmodule
